FILE: design/rem_pkg.sv
// shared constants and types for the reconstruction error metrics block
`timescale 1ns / 1ps

package rem_pkg;

  // sample and count sizing
  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 20;
  localparam int CNT_W       = COUNT_BITS + 1;

  // accumulator widths
  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int SSE_W  = 2 * SAMPLE_BITS + COUNT_BITS + 1;
  localparam int SAE_W  = SAMPLE_BITS + COUNT_BITS + 1;
  localparam int SOS_W  = 2 * SAMPLE_BITS + COUNT_BITS - 1;

  // result widths
  localparam int MSE_W    = 2 * SAMPLE_BITS;
  localparam int MAE_W    = SAMPLE_BITS;
  localparam int REL_BITS = 24;
  localparam int REL_FRAC = 16;
  localparam int REL_SH   = 2 * (REL_BITS - REL_FRAC);

  // shared divider sizing
  localparam int DIV_NUM_W  = SSE_W + 2 * REL_FRAC;
  localparam int DIV_DEN_W  = (SOS_W > CNT_W) ? SOS_W : CNT_W;
  localparam int DIV_STEPS  = DIV_NUM_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  // square root sizing
  localparam int SQRT_IN_W  = 2 * REL_BITS;
  localparam int SQRT_REM_W = REL_BITS + 2;
  localparam int SQRT_STEPS = REL_BITS;
  localparam int SQRT_CNT_W = $clog2(SQRT_STEPS + 1);

  // saturation limits
  localparam logic [CNT_W-1:0] CNT_CAP = {1'b1, {COUNT_BITS{1'b0}}};
  localparam logic [MSE_W-1:0] MSE_CAP =
    {{(SAMPLE_BITS - 1){1'b1}}, {SAMPLE_BITS{1'b0}}, 1'b1};
  localparam logic [MAE_W-1:0] MAE_CAP = {MAE_W{1'b1}};

  // accumulator commands from the sequencer
  typedef struct packed {
    logic mul_err;
    logic add_err;
    logic add_orig;
    logic clear;
  } acc_ctrl_t;

  // running per-tensor totals
  typedef struct packed {
    logic [CNT_W-1:0]       cnt;
    logic [SSE_W-1:0]       sse;
    logic [SAE_W-1:0]       sae;
    logic [SOS_W-1:0]       sos;
    logic [SAMPLE_BITS-1:0] max_err;
    logic [CNT_W-1:0]       zero_orig;
    logic [CNT_W-1:0]       zero_recon;
  } acc_t;

  // status of an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

FILE: design/rem_acc.sv
// per-pair accumulators around one shared squaring multiplier
`timescale 1ns / 1ps

module rem_acc (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  rem_pkg::acc_ctrl_t                   ctrl_i,
  input  logic [rem_pkg::SAMPLE_BITS-1:0]      orig_i,
  input  logic [rem_pkg::SAMPLE_BITS-1:0]      recon_i,
  output rem_pkg::acc_t                        acc_o
);

  localparam int SW = rem_pkg::SAMPLE_BITS;

  logic [SW:0]                 diff;
  logic [SW:0]                 diff_abs;
  logic [SW:0]                 orig_abs;
  logic [SW-1:0]               err;
  logic [SW-1:0]               mul_a;
  logic [rem_pkg::PROD_W-1:0]  prod_q;
  logic [rem_pkg::SSE_W:0]     sse_sum;
  logic [rem_pkg::SAE_W:0]     sae_sum;
  logic [rem_pkg::SOS_W:0]     sos_sum;
  rem_pkg::acc_t               acc_q, acc_d;

  // sign-extended difference and magnitudes
  assign diff     = {orig_i[SW-1], orig_i} - {recon_i[SW-1], recon_i};
  assign diff_abs = diff[SW] ? (~diff + 1'b1) : diff;
  assign orig_abs = orig_i[SW-1] ? (~{orig_i[SW-1], orig_i} + 1'b1) : {orig_i[SW-1], orig_i};
  assign err      = diff_abs[SW-1:0];

  // error squared first, then original squared
  assign mul_a = ctrl_i.add_err ? orig_abs[SW-1:0] : err;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_err || ctrl_i.add_err) begin
      prod_q <= mul_a * mul_a;
    end
  end

  assign sse_sum = {1'b0, acc_q.sse} + (rem_pkg::SSE_W + 1)'(prod_q);
  assign sae_sum = {1'b0, acc_q.sae} + (rem_pkg::SAE_W + 1)'(err);
  assign sos_sum = {1'b0, acc_q.sos} + (rem_pkg::SOS_W + 1)'(prod_q);

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (ctrl_i.add_err) begin
      acc_d.sse = sse_sum[rem_pkg::SSE_W] ? '1 : sse_sum[rem_pkg::SSE_W-1:0];
      acc_d.sae = sae_sum[rem_pkg::SAE_W] ? '1 : sae_sum[rem_pkg::SAE_W-1:0];
      if (acc_q.cnt != rem_pkg::CNT_CAP) begin
        acc_d.cnt = acc_q.cnt + rem_pkg::CNT_W'(1);
      end
      if (orig_i == '0 && acc_q.zero_orig != rem_pkg::CNT_CAP) begin
        acc_d.zero_orig = acc_q.zero_orig + rem_pkg::CNT_W'(1);
      end
      if (recon_i == '0 && acc_q.zero_recon != rem_pkg::CNT_CAP) begin
        acc_d.zero_recon = acc_q.zero_recon + rem_pkg::CNT_W'(1);
      end
      if (err > acc_q.max_err) begin
        acc_d.max_err = err;
      end
    end else if (ctrl_i.add_orig) begin
      acc_d.sos = sos_sum[rem_pkg::SOS_W] ? '1 : sos_sum[rem_pkg::SOS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

FILE: design/rem_div.sv
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module rem_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [rem_pkg::DIV_NUM_W-1:0]      num_i,
  input  logic [rem_pkg::DIV_DEN_W-1:0]      den_i,
  output rem_pkg::unit_sts_t                 sts_o,
  output logic [rem_pkg::DIV_NUM_W-1:0]      quo_o
);

  localparam int NW = rem_pkg::DIV_NUM_W;
  localparam int DW = rem_pkg::DIV_DEN_W;

  logic [DW-1:0]                 den_q;
  logic [DW-1:0]                 rem_q;
  logic [NW-1:0]                 num_q;
  logic [rem_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                          busy_q;
  logic                          done_q;
  logic [DW:0]                   rem_sh;
  logic [DW:0]                   rem_sub;
  logic                          fits;

  assign rem_sh  = {rem_q, num_q[NW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign fits    = rem_sh >= {1'b0, den_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= rem_pkg::DIV_CNT_W'(rem_pkg::DIV_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == rem_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath, quotient bits shift in behind the dividend
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      num_q <= num_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      num_q <= {num_q[NW-2:0], fits};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quo_o      = num_q;

endmodule

FILE: design/rem_sqrt.sv
// digit-by-digit integer square root, one root bit per cycle
`timescale 1ns / 1ps

module rem_sqrt (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [rem_pkg::SQRT_IN_W-1:0]      rad_i,
  output rem_pkg::unit_sts_t                 sts_o,
  output logic [rem_pkg::REL_BITS-1:0]       root_o
);

  localparam int IW = rem_pkg::SQRT_IN_W;
  localparam int RW = rem_pkg::SQRT_REM_W;
  localparam int QW = rem_pkg::REL_BITS;

  logic [IW-1:0]                  rad_q;
  logic [RW-1:0]                  rem_q;
  logic [QW-1:0]                  root_q;
  logic [rem_pkg::SQRT_CNT_W-1:0] cnt_q;
  logic                           busy_q;
  logic                           done_q;
  logic [RW+1:0]                  rem_sh;
  logic [RW+1:0]                  trial;
  logic [RW+1:0]                  rem_sub;
  logic                           fits;

  assign rem_sh  = {rem_q, rad_q[IW-1:IW-2]};
  assign trial   = (RW + 2)'({root_q, 2'b01});
  assign rem_sub = rem_sh - trial;
  assign fits    = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= rem_pkg::SQRT_CNT_W'(rem_pkg::SQRT_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == rem_pkg::SQRT_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[IW-3:0], 2'b00};
      rem_q  <= fits ? rem_sub[RW-1:0] : rem_sh[RW-1:0];
      root_q <= {root_q[QW-2:0], fits};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign root_o     = root_q;

endmodule

FILE: design/reconstruction_error_metrics.sv
// top level: sequencer, result registers and output handshake for error metrics
`timescale 1ns / 1ps

// Reconstruction error metrics over one tensor. Each transaction on the input
// carries an original and a reconstructed signed 16-bit sample and a last flag.
// A pair that is not last runs the accept cycle, then two squarings through a
// single shared 16x16 multiplier (error squared, then original squared), each
// registered and added into saturating accumulators. A last pair then runs the
// final arithmetic on two bit-serial units: a shared restoring divider (used
// for the mean squared error, the mean absolute error and sse*2^32/sos) and a
// square root unit. The divide and root for the relative error are skipped
// when sos is zero or the ratio saturates. in_stall_o stays high from the
// accept until the result is loaded. The result sits in an output register,
// so a new tensor can start while the previous result still waits on
// out_stall_i. All accumulators clear when the result is loaded.

module reconstruction_error_metrics (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [rem_pkg::SAMPLE_BITS-1:0] orig_sample_i,
  input  logic signed [rem_pkg::SAMPLE_BITS-1:0] recon_sample_i,
  input  logic                                last_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [rem_pkg::MSE_W-1:0]           mean_sq_error_o,
  output logic [rem_pkg::MAE_W-1:0]           mean_abs_error_o,
  output logic [rem_pkg::SAMPLE_BITS-1:0]     max_abs_error_o,
  output logic [rem_pkg::REL_BITS-1:0]        rel_rms_error_o,
  output logic [rem_pkg::CNT_W-1:0]           element_total_o,
  output logic [rem_pkg::CNT_W-1:0]           zeros_in_original_o,
  output logic [rem_pkg::CNT_W-1:0]           zeros_in_recon_o
);

  // sequencer states, one-hot
  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_MUL_E   = 10'b00_0000_0010,
    S_ADD_E   = 10'b00_0000_0100,
    S_ADD_O   = 10'b00_0000_1000,
    S_DIV_MSE = 10'b00_0001_0000,
    S_DIV_MAE = 10'b00_0010_0000,
    S_REL_CHK = 10'b00_0100_0000,
    S_DIV_REL = 10'b00_1000_0000,
    S_SQRT    = 10'b01_0000_0000,
    S_OUT     = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // captured transaction
  logic [rem_pkg::SAMPLE_BITS-1:0] orig_q;
  logic [rem_pkg::SAMPLE_BITS-1:0] recon_q;
  logic                            last_q;
  logic                            in_accept;

  // accumulators
  rem_pkg::acc_ctrl_t acc_ctrl;
  rem_pkg::acc_t      acc;

  // shared divider and root unit
  logic                              div_start;
  logic [rem_pkg::DIV_NUM_W-1:0]     div_num;
  logic [rem_pkg::DIV_DEN_W-1:0]     div_den;
  rem_pkg::unit_sts_t                div_sts;
  logic [rem_pkg::DIV_NUM_W-1:0]     div_quo;
  logic                              sqrt_start;
  rem_pkg::unit_sts_t                sqrt_sts;
  logic [rem_pkg::REL_BITS-1:0]      sqrt_root;

  // intermediate results
  logic [rem_pkg::MSE_W-1:0]    mse_q;
  logic [rem_pkg::MAE_W-1:0]    mae_q;
  logic [rem_pkg::REL_BITS-1:0] rel_q;
  logic                         sos_zero;
  logic                         rel_sat;
  logic [rem_pkg::SSE_W-1:0]    sse_hi;

  // output register
  logic out_valid_q;
  logic out_free;
  logic out_load;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == S_OUT) && out_free;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      orig_q  <= orig_sample_i;
      recon_q <= recon_sample_i;
      last_q  <= last_i;
    end
  end

  // relative error special cases: no original energy, or an rms ratio of 256 or more
  assign sse_hi   = acc.sse >> rem_pkg::REL_SH;
  assign sos_zero = (acc.sos == '0);
  assign rel_sat  = sse_hi >= rem_pkg::SSE_W'(acc.sos);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) state_d = S_MUL_E;
      end
      S_MUL_E: state_d = S_ADD_E;
      S_ADD_E: state_d = S_ADD_O;
      S_ADD_O: state_d = last_q ? S_DIV_MSE : S_IDLE;
      S_DIV_MSE: begin
        if (div_sts.done) state_d = S_DIV_MAE;
      end
      S_DIV_MAE: begin
        if (div_sts.done) state_d = S_REL_CHK;
      end
      S_REL_CHK: state_d = (sos_zero || rel_sat) ? S_OUT : S_DIV_REL;
      S_DIV_REL: begin
        if (div_sts.done) state_d = S_SQRT;
      end
      S_SQRT: begin
        if (sqrt_sts.done) state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // accumulator commands
  always_comb begin
    acc_ctrl          = '0;
    acc_ctrl.mul_err  = (state_q == S_MUL_E);
    acc_ctrl.add_err  = (state_q == S_ADD_E);
    acc_ctrl.add_orig = (state_q == S_ADD_O);
    acc_ctrl.clear    = out_load;
  end

  // divider operand selection: sse/count, sae/count, then sse*2^32/sos
  always_comb begin
    div_start = 1'b0;
    div_num   = rem_pkg::DIV_NUM_W'(acc.sse);
    div_den   = rem_pkg::DIV_DEN_W'(acc.cnt);
    unique case (state_q)
      S_ADD_O: begin
        div_start = last_q;
      end
      S_DIV_MSE: begin
        div_start = div_sts.done;
        div_num   = rem_pkg::DIV_NUM_W'(acc.sae);
      end
      S_REL_CHK: begin
        div_start = !(sos_zero || rel_sat);
        div_num   = {acc.sse, {(2 * rem_pkg::REL_FRAC){1'b0}}};
        div_den   = rem_pkg::DIV_DEN_W'(acc.sos);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  assign sqrt_start = (state_q == S_DIV_REL) && div_sts.done;

  // capture results as the units finish, saturating the means
  always_ff @(posedge clk_i) begin
    if (state_q == S_DIV_MSE && div_sts.done) begin
      mse_q <= (div_quo > rem_pkg::DIV_NUM_W'(rem_pkg::MSE_CAP)) ?
               rem_pkg::MSE_CAP : div_quo[rem_pkg::MSE_W-1:0];
    end
    if (state_q == S_DIV_MAE && div_sts.done) begin
      mae_q <= (div_quo > rem_pkg::DIV_NUM_W'(rem_pkg::MAE_CAP)) ?
               rem_pkg::MAE_CAP : div_quo[rem_pkg::MAE_W-1:0];
    end
    if (state_q == S_REL_CHK) begin
      rel_q <= sos_zero ? '0 : '1;
    end
    if (state_q == S_SQRT && sqrt_sts.done) begin
      rel_q <= sqrt_root;
    end
  end

  // output register holds while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      mean_sq_error_o     <= mse_q;
      mean_abs_error_o    <= mae_q;
      max_abs_error_o     <= acc.max_err;
      rel_rms_error_o     <= rel_q;
      element_total_o     <= acc.cnt;
      zeros_in_original_o <= acc.zero_orig;
      zeros_in_recon_o    <= acc.zero_recon;
    end
  end

  assign out_valid_o = out_valid_q;

  rem_acc u_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (acc_ctrl),
    .orig_i  (orig_q),
    .recon_i (recon_q),
    .acc_o   (acc)
  );

  rem_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .sts_o   (div_sts),
    .quo_o   (div_quo)
  );

  rem_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (div_quo[rem_pkg::SQRT_IN_W-1:0]),
    .sts_o   (sqrt_sts),
    .root_o  (sqrt_root)
  );

endmodule
